// File: hdl/rfs_pkg.sv
// Shared types, constants and codes for the RTCP feedback stripper.
`timescale 1ns / 1ps
`default_nettype none

package rfs_pkg;

    // Number of low packet length bits that take part in the parse.
    localparam int LENGTH_BITS = 16;
    localparam logic [15:0] LEN_MASK = 16'((32'd1 << LENGTH_BITS) - 32'd1);

    // Sub-packet header constants.
    localparam logic [7:0] VER_MASK       = 8'hc0;
    localparam logic [7:0] VER_TWO        = 8'h80;
    localparam logic [7:0] COUNT_MASK     = 8'h1f;
    localparam logic [7:0] PT_SR          = 8'd200;
    localparam logic [7:0] PT_RR          = 8'd201;
    localparam logic [7:0] PT_RTPFB       = 8'd205;
    localparam logic [7:0] PT_PSFB        = 8'd206;
    localparam logic [9:0] REPORT_BYTES   = 10'd24;
    localparam logic [15:0] SR_MIN_BYTES  = 16'd28;
    localparam logic [15:0] HDR_MIN_BYTES = 16'd8;
    localparam logic [15:0] WORD_BYTES    = 16'd4;

    // Packed word widths on the stream ports.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 56;
    localparam int OUT_TUSER_W = 3;

    // Verdict codes on the last word.
    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_MALFORMED = 2'd1,
        VERDICT_EMPTY     = 2'd2
    } verdict_t;

    // Result of checking one sub-packet header word.
    typedef struct packed {
        logic        ok;
        logic        feedback;
        logic [16:0] sub_words;
        logic [18:0] sub_bytes;
    } hdr_info_t;

endpackage

`default_nettype wire

// File: hdl/rfs_hdr_check.sv
// Combinational check of one RTCP sub-packet header word.
`timescale 1ns / 1ps
`default_nettype none

module rfs_hdr_check
    import rfs_pkg::*;
(
    input  wire logic [31:0] word,
    input  wire logic [15:0] bytes_left,
    output hdr_info_t        info
);

    logic [7:0]  b0;
    logic [7:0]  pt;
    logic [18:0] len_bytes;
    logic [9:0]  report_bytes;
    logic        ver_ok;
    logic        pt_ok;
    logic        fits;
    logic        sr_ok;
    logic        rep_ok;

    // Field extraction and stated length in bytes.
    assign b0        = word[31:24];
    assign pt        = word[23:16];
    assign len_bytes = {(17'(word[15:0]) + 17'd1), 2'b00};
    assign report_bytes = 10'(b0 & COUNT_MASK) * REPORT_BYTES;

    // Individual header checks.
    always_comb
    begin
        ver_ok = ((b0 & VER_MASK) == VER_TWO);
        pt_ok  = (pt >= PT_SR) && (pt <= PT_PSFB);
        fits   = (len_bytes <= 19'(bytes_left));
        sr_ok  = !((pt == PT_SR) && (bytes_left < SR_MIN_BYTES));
        rep_ok = !(((pt == PT_SR) || (pt == PT_RR)) && (len_bytes < 19'(report_bytes)));
    end

    // Collected result for the parser.
    always_comb
    begin
        info.ok        = ver_ok && pt_ok && fits && sr_ok && rep_ok;
        info.feedback  = (pt == PT_RTPFB) || (pt == PT_PSFB);
        info.sub_words = {1'b0, word[15:0]};
        info.sub_bytes = len_bytes;
    end

endmodule

`default_nettype wire

// File: hdl/rfs_parser.sv
// Per-word parse state of the compound packet and the verdict on the last word.
`timescale 1ns / 1ps
`default_nettype none

module rfs_parser
    import rfs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        advance,
    input  wire logic [31:0] word,
    input  wire logic [15:0] packet_bytes,
    input  wire logic        last_word,
    output logic             drop_word,
    output verdict_t         verdict,
    output logic [15:0]      new_length
);

    logic [15:0] byte_offset_reg, byte_offset_next;
    logic [16:0] words_left_reg, words_left_next;
    logic        feedback_reg, feedback_next;
    logic        tail_reg, tail_next;
    logic        error_reg, error_next;
    logic [15:0] removed_reg, removed_next;

    logic [15:0] pb;
    logic [15:0] left;
    logic [16:0] off_sum;
    logic [15:0] end_gap;
    logic        end_ok;
    hdr_info_t   hdr;

    // Bytes of the packet from the current word on.
    assign pb      = packet_bytes & LEN_MASK;
    assign left    = (pb > byte_offset_reg) ? (pb - byte_offset_reg) : 16'd0;
    assign off_sum = 17'(byte_offset_reg) + 17'(WORD_BYTES);
    assign end_gap = pb - byte_offset_reg;
    assign end_ok  = (pb > byte_offset_reg) && (end_gap <= WORD_BYTES);

    rfs_hdr_check u_hdr_check (
        .word       (word),
        .bytes_left (left),
        .info       (hdr)
    );

    // Next parse state, drop mark and verdict for the word at hand.
    always_comb
    begin
        words_left_next = words_left_reg;
        feedback_next   = feedback_reg;
        tail_next       = tail_reg;
        error_next      = error_reg;
        removed_next    = removed_reg;
        drop_word       = 1'b0;
        verdict         = VERDICT_OK;
        new_length      = 16'd0;

        if (!error_reg)
        begin
            if (words_left_reg != 17'd0)
            begin
                drop_word       = feedback_reg;
                words_left_next = words_left_reg - 17'd1;
            end
            else if (!tail_reg)
            begin
                if (left < HDR_MIN_BYTES)
                begin
                    tail_next = 1'b1;
                end
                else if (!hdr.ok)
                begin
                    error_next    = 1'b1;
                    feedback_next = 1'b0;
                end
                else
                begin
                    feedback_next   = hdr.feedback;
                    words_left_next = hdr.sub_words;
                    if (hdr.feedback)
                    begin
                        drop_word    = 1'b1;
                        removed_next = removed_reg + hdr.sub_bytes[15:0];
                    end
                end
            end
        end

        // The offset saturates at the top of the length range.
        if (off_sum > 17'(LEN_MASK))
            byte_offset_next = LEN_MASK;
        else
            byte_offset_next = off_sum[15:0];

        if (last_word)
        begin
            if (error_next || !end_ok || (removed_next > pb))
            begin
                verdict    = VERDICT_MALFORMED;
                new_length = pb;
            end
            else
            begin
                new_length = pb - removed_next;
                verdict    = (new_length == 16'd0) ? VERDICT_EMPTY : VERDICT_OK;
            end
            // Every packet starts from a clean parse state.
            byte_offset_next = 16'd0;
            words_left_next  = 17'd0;
            feedback_next    = 1'b0;
            tail_next        = 1'b0;
            error_next       = 1'b0;
            removed_next     = 16'd0;
        end
    end

    // Parse state registers, updated as each word moves to the output.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_offset_reg <= 16'd0;
            words_left_reg  <= 17'd0;
            feedback_reg    <= 1'b0;
            tail_reg        <= 1'b0;
            error_reg       <= 1'b0;
            removed_reg     <= 16'd0;
        end
        else if (advance)
        begin
            byte_offset_reg <= byte_offset_next;
            words_left_reg  <= words_left_next;
            feedback_reg    <= feedback_next;
            tail_reg        <= tail_next;
            error_reg       <= error_next;
            removed_reg     <= removed_next;
        end
    end

    // A last word leaves the parser at the start of a packet.
    a_clean_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_word |=> (byte_offset_reg == 16'd0) && (removed_reg == 16'd0)
                                 && !error_reg && !tail_reg)
        else $error("parse state not cleared after last word");

    // Once an error is seen no word is marked and no sub-packet is open.
    a_error_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        error_reg |-> !drop_word && (words_left_reg == 17'd0))
        else $error("parsing continued after a header error");

    // The unparsed tail never overlaps an open sub-packet.
    a_tail_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        tail_reg |-> (words_left_reg == 17'd0) && !drop_word)
        else $error("tail mode with an open sub-packet");

    // Words of an open sub-packet are counted down one per word.
    a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
        advance && !last_word && !error_reg && (words_left_reg != 17'd0)
            |=> words_left_reg == $past(words_left_reg) - 17'd1)
        else $error("sub-packet word count skipped");

endmodule

`default_nettype wire

// File: hdl/rtcp_feedback_stripper_top.sv
// An accepted word passes from the input register to the output register.
// Throughput: one word per cycle; the input register and the output register each
// hold one word and move together whenever the output side is ready.
// The parse state is updated as a word moves from the input to the output register.
// Reset clears both register valids and the whole parse state.
`timescale 1ns / 1ps
`default_nettype none

module rtcp_feedback_stripper_top
    import rfs_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // data_word[31:0], valid_bytes[34:32], packet_bytes[50:35], zero fill [55:51]
    input  wire logic [IN_TDATA_W-1:0]  s_tdata,
    input  wire logic                   s_tlast,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // out_word[31:0], out_valid_bytes[34:32], new_length[50:35], zero fill [55:51]
    output logic [OUT_TDATA_W-1:0]      m_tdata,
    // drop_word[0], verdict[2:1]
    output logic [OUT_TUSER_W-1:0]      m_tuser,
    output logic                        m_tlast
);

    logic        in_valid_reg;
    logic [31:0] in_word_reg;
    logic [2:0]  in_vb_reg;
    logic [15:0] in_pb_reg;
    logic        in_last_reg;

    logic        out_valid_reg;
    logic [31:0] out_word_reg;
    logic [2:0]  out_vb_reg;
    logic [15:0] out_len_reg;
    logic        out_drop_reg;
    verdict_t    out_verdict_reg;
    logic        out_last_reg;

    logic        out_free;
    logic        advance;
    logic        drop_word;
    verdict_t    verdict;
    logic [15:0] new_length;

    // Handshake: a word moves on whenever the output register can take it.
    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_word_reg <= s_tdata[31:0];
            in_vb_reg   <= s_tdata[34:32];
            in_pb_reg   <= s_tdata[50:35];
            in_last_reg <= s_tlast;
        end
    end

    rfs_parser u_parser (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .word         (in_word_reg),
        .packet_bytes (in_pb_reg),
        .last_word    (in_last_reg),
        .drop_word    (drop_word),
        .verdict      (verdict),
        .new_length   (new_length)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_word_reg    <= in_word_reg;
            out_vb_reg      <= in_vb_reg;
            out_len_reg     <= new_length;
            out_drop_reg    <= drop_word;
            out_verdict_reg <= verdict;
            out_last_reg    <= in_last_reg;
        end
    end

    // Output word packing.
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_len_reg, out_vb_reg, out_word_reg};
    assign m_tuser  = {out_verdict_reg, out_drop_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// File: tb/sv/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the RTCP feedback stripper top level.

module tb;
    import rfs_pkg::*;

    // Packet types used by the stimulus beyond those in the package.
    localparam logic [7:0] PT_BELOW = 8'd199;
    localparam logic [7:0] PT_SDES  = 8'd202;
    localparam logic [7:0] PT_BYE   = 8'd203;
    localparam logic [7:0] PT_APP   = 8'd204;
    localparam logic [7:0] PT_XR    = 8'd207;

    localparam int RANDOM_WORDS = 1270;
    localparam int CYCLE_LIMIT  = 400000;

    // One expected output word.
    typedef struct {
        logic [31:0] word;
        logic [2:0]  valid_bytes;
        logic        drop;
        logic        last;
        verdict_t    verdict;
        logic [15:0] new_length;
    } stripped_word_t;

    // Tracks the parse of the packet in flight and holds the words still due at the output.
    class strip_scoreboard;
        stripped_word_t pending[$];
        int             errors;
        logic [15:0]    offset;
        logic [16:0]    sub_words_left;
        bit             in_feedback;
        bit             in_tail;
        bit             bad_header;
        logic [15:0]    removed;

        function new();
            errors = 0;
            clear_parse();
        endfunction

        function void clear_parse();
            offset         = '0;
            sub_words_left = '0;
            in_feedback    = 1'b0;
            in_tail        = 1'b0;
            bad_header     = 1'b0;
            removed        = '0;
        endfunction

        // Checks one sub-packet header against the bytes still left in the packet.
        function bit header_good(input logic [31:0] w, input int unsigned left,
                                 output int unsigned sub_bytes);
            logic [7:0] b0;
            logic [7:0] pt;
            bit         ok;
            b0 = w[31:24];
            pt = w[23:16];
            sub_bytes = ({16'd0, w[15:0]} + 32'd1) << 2;
            ok = 1'b1;
            if ((b0 & VER_MASK) != VER_TWO)
                ok = 1'b0;
            if (pt < PT_SR || pt > PT_PSFB)
                ok = 1'b0;
            if (sub_bytes > left)
                ok = 1'b0;
            if (pt == PT_SR || pt == PT_RR)
            begin
                if (pt == PT_SR && left < 32'(SR_MIN_BYTES))
                    ok = 1'b0;
                if (sub_bytes < 32'(b0 & COUNT_MASK) * 32'(REPORT_BYTES))
                    ok = 1'b0;
            end
            return ok;
        endfunction

        // Works out the output word for one accepted input word.
        function void note_word(input logic [31:0] w, input logic [2:0] vb,
                                input logic [15:0] len_in, input logic last);
            int unsigned    pb;
            int unsigned    off;
            int unsigned    left;
            int unsigned    sub_bytes;
            int unsigned    nxt;
            stripped_word_t e;
            pb   = 32'(len_in & LEN_MASK);
            off  = 32'(offset);
            left = (pb > off) ? pb - off : 0;
            e.word        = w;
            e.valid_bytes = vb;
            e.drop        = 1'b0;
            e.last        = last;
            e.verdict     = VERDICT_OK;
            e.new_length  = '0;

            // Header parse, or progress through the current sub-packet.
            if (!bad_header)
            begin
                if (sub_words_left != 0)
                begin
                    e.drop = in_feedback;
                    sub_words_left = sub_words_left - 17'd1;
                end
                else if (!in_tail)
                begin
                    if (left < 32'(HDR_MIN_BYTES))
                        in_tail = 1'b1;
                    else if (!header_good(w, left, sub_bytes))
                    begin
                        bad_header  = 1'b1;
                        in_feedback = 1'b0;
                    end
                    else
                    begin
                        in_feedback = (w[23:16] == PT_RTPFB || w[23:16] == PT_PSFB);
                        sub_words_left = 17'((sub_bytes >> 2) - 1);
                        if (in_feedback)
                        begin
                            e.drop  = 1'b1;
                            removed = 16'(32'(removed) + sub_bytes);
                        end
                    end
                end
            end

            // The byte position saturates at the top of the length range.
            nxt = off + 4;
            if (nxt > 32'(LEN_MASK))
                nxt = 32'(LEN_MASK);
            offset = 16'(nxt);

            // Verdict and remaining length on the last word.
            if (last)
            begin
                if (bad_header || !(pb > off && pb - off <= 4) || 32'(removed) > pb)
                begin
                    e.verdict    = VERDICT_MALFORMED;
                    e.new_length = 16'(pb);
                end
                else
                begin
                    e.new_length = 16'(pb - 32'(removed));
                    e.verdict    = (e.new_length == 16'd0) ? VERDICT_EMPTY : VERDICT_OK;
                end
                clear_parse();
            end
            pending.push_back(e);
        endfunction

        task report(input string field, input logic [31:0] want, input logic [31:0] got);
            $display("mismatch on %s: expected %0h, got %0h", field, want, got);
            errors++;
        endtask

        // Compares one output word with the oldest expectation.
        task check_word(input logic [OUT_TDATA_W-1:0] tdata,
                        input logic [OUT_TUSER_W-1:0] tuser, input logic tlast);
            stripped_word_t e;
            if (pending.size() == 0)
            begin
                report("unexpected output word", 32'd0, tdata[31:0]);
                return;
            end
            e = pending.pop_front();
            if (tdata[31:0] !== e.word)
                report("out_word", e.word, tdata[31:0]);
            if (tdata[34:32] !== e.valid_bytes)
                report("out_valid_bytes", 32'(e.valid_bytes), 32'(tdata[34:32]));
            if (tdata[50:35] !== e.new_length)
                report("new_length", 32'(e.new_length), 32'(tdata[50:35]));
            if (tuser[0] !== e.drop)
                report("drop_word", 32'(e.drop), 32'(tuser[0]));
            if (tuser[2:1] !== e.verdict)
                report("verdict", 32'(e.verdict), 32'(tuser[2:1]));
            if (tlast !== e.last)
                report("out_last", 32'(e.last), 32'(tlast));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tlast = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;

    strip_scoreboard sb;
    int              cycle_count = 0;
    int              words_sent = 0;
    bit              calm = 1'b0;

    // Packet under construction: words, their valid byte counts and stated lengths.
    logic [31:0] pkt_word[$];
    logic [2:0]  pkt_vb[$];
    logic [15:0] pkt_len[$];
    int          hdr_pos[$];

    rtcp_feedback_stripper_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Output side stalls about a quarter of the time outside calm stretches.
    always @(negedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 25);
    end

    // Note accepted input words and check accepted output words.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_word(s_tdata[31:0], s_tdata[34:32], s_tdata[50:35], s_tlast);
            if (m_tvalid && m_tready)
                sb.check_word(m_tdata, m_tuser, m_tlast);
        end
    end

    // Presents one word and holds it until it is accepted.
    task send_word(input logic [31:0] w, input logic [2:0] vb, input logic [15:0] len,
                   input logic last);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 25)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, len, vb, w};
        s_tlast  <= last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        words_sent++;
    endtask

    task send_packet();
        for (int i = 0; i < pkt_word.size(); i++)
            send_word(pkt_word[i], pkt_vb[i], pkt_len[i], i == pkt_word.size() - 1);
        pkt_word.delete();
        pkt_vb.delete();
        pkt_len.delete();
        hdr_pos.delete();
    endtask

    // Appends a sub-packet whose length field matches its word count.
    task add_sub(input logic [7:0] pt, input int count, input int words, input logic [1:0] ver);
        hdr_pos.push_back(pkt_word.size());
        pkt_word.push_back({ver, 1'($urandom_range(1)), 5'(count), pt, 16'(words - 1)});
        for (int i = 1; i < words; i++)
            pkt_word.push_back($urandom);
    endtask

    task add_random_sub(input bit feedback_only);
        int kind;
        int c;
        kind = feedback_only ? 5 + $urandom_range(1) : $urandom_range(6);
        c = $urandom_range(2);
        case (kind)
            0: add_sub(PT_SR, c, 7 + 6 * c, 2'd2);
            1: add_sub(PT_RR, c, 2 + 6 * c, 2'd2);
            2: add_sub(PT_SDES, $urandom_range(31), $urandom_range(1, 5), 2'd2);
            3: add_sub(PT_BYE, $urandom_range(31), $urandom_range(1, 5), 2'd2);
            4: add_sub(PT_APP, $urandom_range(31), $urandom_range(1, 5), 2'd2);
            5: add_sub(PT_RTPFB, $urandom_range(31), $urandom_range(3, 6), 2'd2);
            default: add_sub(PT_PSFB, $urandom_range(31), $urandom_range(3, 6), 2'd2);
        endcase
    endtask

    // Adds an optional short tail and fills in the byte counts and length.
    task close_packet(input int tail_vb);
        int n;
        int last_vb;
        if (tail_vb != 0)
            pkt_word.push_back($urandom);
        n = pkt_word.size();
        last_vb = (tail_vb != 0) ? tail_vb : 4;
        for (int i = 0; i < n; i++)
        begin
            pkt_vb.push_back((i == n - 1) ? 3'(last_vb) : 3'd4);
            pkt_len.push_back(16'(4 * (n - 1) + last_vb));
        end
    endtask

    task build_good();
        bit fb_only;
        int subs;
        fb_only = ($urandom_range(9) == 0);
        subs = $urandom_range(1, 4);
        repeat (subs)
            add_random_sub(fb_only);
        close_packet(($urandom_range(2) == 0) ? $urandom_range(1, 4) : 0);
    endtask

    // Fully random words, byte counts and lengths.
    task build_noise();
        int          n;
        logic [15:0] len;
        n = $urandom_range(1, 6);
        len = 16'($urandom);
        for (int i = 0; i < n; i++)
        begin
            pkt_word.push_back($urandom);
            pkt_vb.push_back(3'($urandom_range(7)));
            pkt_len.push_back(($urandom_range(3) == 0) ? 16'($urandom) : len);
        end
    endtask

    // A well-formed packet with one defect put in.
    task build_broken();
        int          h;
        int          k;
        int          v;
        logic [31:0] hw;
        build_good();
        h = hdr_pos[$urandom_range(hdr_pos.size() - 1)];
        hw = pkt_word[h];
        case ($urandom_range(7))
            0:
            begin
                v = $urandom_range(2);
                hw[31:30] = (v == 2) ? 2'd3 : 2'(v);
            end
            1: hw[23:16] = $urandom_range(1) ? PT_XR : 8'($urandom);
            2: hw[15:0] = 16'($urandom);
            3:
            begin
                // The stream ends before the stated length.
                if (pkt_word.size() > 1)
                begin
                    k = $urandom_range(1, pkt_word.size() - 1);
                    repeat (k)
                    begin
                        void'(pkt_word.pop_back());
                        void'(pkt_vb.pop_back());
                        void'(pkt_len.pop_back());
                    end
                end
            end
            4:
            begin
                // Words run on past the stated length.
                k = $urandom_range(1, 3);
                repeat (k)
                begin
                    pkt_word.push_back($urandom);
                    pkt_vb.push_back(3'd4);
                    pkt_len.push_back(pkt_len[0]);
                end
            end
            5:
            begin
                k = $urandom_range(1) ? 0 : $urandom;
                foreach (pkt_len[i])
                    pkt_len[i] = 16'(k);
            end
            6:
            begin
                // Report count larger than the sub-packet can hold.
                hw[28:24] = 5'd31;
                hw[23:16] = $urandom_range(1) ? PT_SR : PT_RR;
            end
            default:
            begin
                foreach (pkt_len[i])
                    pkt_len[i] = 16'(32'(pkt_len[i]) + 4 * ($urandom_range(2) - 1));
            end
        endcase
        if (pkt_word.size() > h)
            pkt_word[h] = hw;
    endtask

    // Reset, directed packets, random packets, then drain.
    initial
    begin
        int          target;
        int          pkt_count;
        int          pick;
        logic [31:0] hw;
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Receiver report alone, and feedback alone, which leaves nothing.
        add_sub(PT_RR, 0, 2, 2'd2);
        close_packet(0);
        send_packet();
        add_sub(PT_RTPFB, 1, 3, 2'd2);
        close_packet(0);
        send_packet();

        // Sender report, feedback and a two-byte tail.
        add_sub(PT_SR, 1, 13, 2'd2);
        add_sub(PT_PSFB, 15, 4, 2'd2);
        close_packet(2);
        send_packet();

        // Every accepted non-feedback type in one packet.
        add_sub(PT_SR, 0, 7, 2'd2);
        add_sub(PT_RR, 2, 14, 2'd2);
        add_sub(PT_SDES, 1, 3, 2'd2);
        add_sub(PT_BYE, 1, 1, 2'd2);
        add_sub(PT_APP, 0, 2, 2'd2);
        close_packet(4);
        send_packet();

        // Extended reports and types below the range are rejected.
        add_sub(PT_XR, 0, 3, 2'd2);
        close_packet(0);
        send_packet();
        add_sub(PT_BELOW, 0, 2, 2'd2);
        close_packet(0);
        send_packet();

        // Wrong version.
        add_sub(PT_RR, 0, 2, 2'd1);
        close_packet(0);
        send_packet();

        // Stated length far beyond the packet.
        add_sub(PT_RR, 0, 2, 2'd2);
        hw = pkt_word[0];
        hw[15:0] = 16'hffff;
        pkt_word[0] = hw;
        close_packet(0);
        send_packet();

        // Sender report with too few bytes left, receiver report too short for its count.
        add_sub(PT_SR, 0, 2, 2'd2);
        close_packet(0);
        send_packet();
        add_sub(PT_RR, 1, 2, 2'd2);
        close_packet(0);
        send_packet();

        // Zero packet length, and packets that are only a short tail.
        pkt_word.push_back($urandom);
        pkt_vb.push_back(3'd4);
        pkt_len.push_back(16'd0);
        send_packet();
        close_packet(4);
        send_packet();
        close_packet(1);
        send_packet();

        // Stream that ends early, and one that runs past its length.
        add_sub(PT_RR, 1, 8, 2'd2);
        close_packet(0);
        repeat (4)
        begin
            void'(pkt_word.pop_back());
            void'(pkt_vb.pop_back());
            void'(pkt_len.pop_back());
        end
        send_packet();
        add_sub(PT_RR, 0, 2, 2'd2);
        close_packet(0);
        repeat (2)
        begin
            pkt_word.push_back($urandom);
            pkt_vb.push_back(3'd4);
            pkt_len.push_back(16'd8);
        end
        send_packet();

        // Feedback marks followed by a bad header.
        add_sub(PT_PSFB, 0, 3, 2'd2);
        add_sub(PT_XR, 0, 2, 2'd2);
        close_packet(0);
        send_packet();

        // Extreme field values with odd byte counts.
        pkt_word.push_back(32'hffffffff);
        pkt_vb.push_back(3'd7);
        pkt_len.push_back(16'hffff);
        pkt_word.push_back(32'h0);
        pkt_vb.push_back(3'd0);
        pkt_len.push_back(16'hffff);
        send_packet();

        // Mostly well-formed packets, with broken ones and noise mixed in.
        target = words_sent + RANDOM_WORDS;
        pkt_count = 0;
        while (words_sent < target)
        begin
            calm = (pkt_count >= 40 && pkt_count < 60);
            pick = $urandom_range(99);
            if (pick < 75)
                build_good();
            else if (pick < 92)
                build_broken();
            else
                build_noise();
            send_packet();
            pkt_count++;
        end
        calm = 1'b0;
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    // Ends a run that hangs.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb failed");
        $finish;
    end

endmodule

// File: rtcp_feedback_stripper_top.f
hdl/rfs_pkg.sv
hdl/rfs_hdr_check.sv
hdl/rfs_parser.sv
hdl/rtcp_feedback_stripper_top.sv
tb/sv/tb.sv
